[rtl/salc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache model: the
// cache geometry, the access and result transactions and the line layout.
// ----------------------------------------------------------------------------
package salc_pkg;

    // Cache geometry.
    localparam int WAYS         = 4;
    localparam int MAX_SET_BITS = 8;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int MAX_BLK_BITS = 16;

    // Derived widths.
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W     = WAY_W;
    localparam int WAY_CNT_W  = $clog2(WAYS + 1);
    localparam int SET_W      = MAX_SET_BITS;
    localparam int SBITS_W    = $clog2(MAX_SET_BITS + 1);
    localparam int BBITS_W    = $clog2(MAX_BLK_BITS + 1);
    localparam int SUM_W      = $clog2(MAX_SET_BITS + MAX_BLK_BITS + 1);

    // Configuration register fields.
    localparam int CFG_SET_W  = 4;
    localparam int CFG_BLK_W  = 5;
    localparam int CFG_WAYS_W = 3;
    localparam int ADDR_W     = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SET_BITS = 2'd0;
    localparam logic [1:0] REG_BLK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS     = 2'd2;

    // Access codes; the last one makes no access at all.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One access transaction.
    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  opcode;
    } access_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  hits;
        logic        misses;
        logic        evictions;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] eviction_count;
    } result_t;

    // One cache line: valid flag, tag and recency rank (0 is most recent).
    typedef struct packed {
        logic              valid;
        logic [31:0]       tag;
        logic [RANK_W-1:0] rank;
    } line_t;

    // One set: all ways side by side.
    typedef line_t [WAYS-1:0] row_t;

endpackage
`default_nettype wire

[rtl/set_assoc_lru_cache_sim.sv]
`default_nettype none
// An accepted transaction is registered with its set row read from memory;
// the result and its strobe are then registered from the access state.
// A new access is taken only once the block is back in idle, after the set
// memory read and the single lookup/update pass over that set. The receiver
// cannot stall. Reset clears the totals, the configuration and the set valid
// flags at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag-only set-associative cache with LRU replacement. Each set is one row
// of a memory; a per-set flag marks rows never written, which read as the
// reset contents. A two-state sequencer reads the row, then looks up, picks
// a line and writes the row back.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim
    import salc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Access transactions
    input  wire logic              start,
    input  wire access_t           request,
    output      logic              busy,
    // Result transactions
    output      logic              done,
    output      result_t           result,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ACC  = 2'b10
    } state_t;

    state_t              state_reg, state_next;

    logic [CFG_SET_W-1:0]  set_bits_reg;
    logic [CFG_BLK_W-1:0]  blk_bits_reg;
    logic [CFG_WAYS_W-1:0] ways_reg;

    logic [SET_W-1:0]    set_reg;
    logic [31:0]         tag_reg;
    logic [1:0]          op_reg;
    row_t                rdata_reg;
    logic                row_ok_reg;

    row_t                mem [NUM_SETS];
    logic [NUM_SETS-1:0] row_valid_reg;

    logic [31:0]         hit_total_reg, miss_total_reg, evict_total_reg;
    logic                done_reg;
    result_t             result_reg;

    logic [SBITS_W-1:0]  s_eff;
    logic [BBITS_W-1:0]  b_eff;
    logic [WAY_CNT_W-1:0] n_eff;
    logic [SUM_W-1:0]    sb_sum;
    logic [SET_W-1:0]    set_in;
    logic [31:0]         tag_in;
    logic                accept;
    logic                cfg_wr;

    row_t                row_cur, row_new;
    logic [WAYS-1:0]     way_en;
    logic                hit_any, inv_any, is_access, evict;
    logic [WAY_W-1:0]    hit_way, inv_way, vic_way, pick;
    logic [RANK_W-1:0]   pick_rank;
    logic [1:0]          hits_n;
    logic                misses_n, evicts_n;

    // Configuration port: no wait states, writes in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SET_BITS: prdata = {{(32-CFG_SET_W){1'b0}}, set_bits_reg};
            REG_BLK_BITS: prdata = {{(32-CFG_BLK_W){1'b0}}, blk_bits_reg};
            REG_WAYS:     prdata = {{(32-CFG_WAYS_W){1'b0}}, ways_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= CFG_SET_W'(4);
            blk_bits_reg <= CFG_BLK_W'(4);
            ways_reg     <= CFG_WAYS_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SET_BITS: set_bits_reg <= pwdata[CFG_SET_W-1:0];
                REG_BLK_BITS: blk_bits_reg <= pwdata[CFG_BLK_W-1:0];
                REG_WAYS:     ways_reg     <= pwdata[CFG_WAYS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective configuration: each register saturated into its range.
    always_comb
    begin
        if (set_bits_reg == '0)
            s_eff = SBITS_W'(1);
        else if (set_bits_reg > CFG_SET_W'(MAX_SET_BITS))
            s_eff = SBITS_W'(MAX_SET_BITS);
        else
            s_eff = SBITS_W'(set_bits_reg);

        if (blk_bits_reg == '0)
            b_eff = BBITS_W'(1);
        else if (blk_bits_reg > CFG_BLK_W'(MAX_BLK_BITS))
            b_eff = BBITS_W'(MAX_BLK_BITS);
        else
            b_eff = BBITS_W'(blk_bits_reg);

        if (ways_reg == '0)
            n_eff = WAY_CNT_W'(1);
        else if (ways_reg > CFG_WAYS_W'(WAYS))
            n_eff = WAY_CNT_W'(WAYS);
        else
            n_eff = WAY_CNT_W'(ways_reg);
    end

    // Set index and tag from the incoming address.
    assign sb_sum = SUM_W'(s_eff) + SUM_W'(b_eff);
    assign set_in = SET_W'(request.address >> b_eff)
                    & SET_W'((32'd1 << s_eff) - 32'd1);
    assign tag_in = request.address & (32'hFFFF_FFFF << sb_sum);

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture the transaction and read its set row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg   <= set_in;
            tag_reg   <= tag_in;
            op_reg    <= request.opcode;
            rdata_reg <= mem[set_in];
        end
    end

    // Set valid flags: a row never written reads as the reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_ok_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
                row_ok_reg <= row_valid_reg[set_in];
            if (state_reg == ST_ACC && is_access)
                row_valid_reg[set_reg] <= 1'b1;
        end
    end

    // Current row: stored contents, or invalid lines in way-index rank order.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_ok_reg)
                row_cur[w] = rdata_reg[w];
            else
            begin
                row_cur[w].valid = 1'b0;
                row_cur[w].tag   = rdata_reg[w].tag;
                row_cur[w].rank  = RANK_W'(w);
            end
        end
    end

    // Lookup, line selection and recency update over the ways of the set.
    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        vic_way = '0;
        for (int w = 0; w < WAYS; w++)
            way_en[w] = (WAY_CNT_W'(w) < n_eff);

        // Lowest matching way and lowest invalid way, scanned downwards.
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (way_en[w] && row_cur[w].valid && row_cur[w].tag == tag_reg)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (way_en[w] && !row_cur[w].valid)
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end

        // Least recently used way in use; the lowest wins a tie.
        for (int w = 1; w < WAYS; w++)
        begin
            if (way_en[w] && row_cur[w].rank > row_cur[vic_way].rank)
                vic_way = WAY_W'(w);
        end

        if (hit_any)
            pick = hit_way;
        else if (inv_any)
            pick = inv_way;
        else
            pick = vic_way;
        evict = !hit_any && !inv_any;

        // Move the chosen line to the front; younger lines age by one.
        pick_rank = row_cur[pick].rank;
        for (int w = 0; w < WAYS; w++)
        begin
            row_new[w] = row_cur[w];
            if (row_cur[w].rank < pick_rank)
                row_new[w].rank = row_cur[w].rank + RANK_W'(1);
        end
        row_new[pick].valid = 1'b1;
        row_new[pick].tag   = tag_reg;
        row_new[pick].rank  = '0;
    end

    // Counts for this transaction; the second access of a modify always hits.
    always_comb
    begin
        is_access = (op_reg != OP_UNUSED);
        hits_n    = 2'd0;
        misses_n  = 1'b0;
        evicts_n  = 1'b0;
        case (op_reg)
            OP_LOAD, OP_STORE:
            begin
                hits_n   = {1'b0, hit_any};
                misses_n = !hit_any;
                evicts_n = evict;
            end
            OP_MODIFY:
            begin
                hits_n   = hit_any ? 2'd2 : 2'd1;
                misses_n = !hit_any;
                evicts_n = evict;
            end
            default: ;
        endcase
    end

    // Row write-back.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC && is_access)
            mem[set_reg] <= row_new;
    end

    // Running totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_ACC);
            if (state_reg == ST_ACC)
            begin
                hit_total_reg   <= hit_total_reg + 32'(hits_n);
                miss_total_reg  <= miss_total_reg + 32'(misses_n);
                evict_total_reg <= evict_total_reg + 32'(evicts_n);
            end
        end
    end

    // Result register, loaded in the access state and held; the strobe marks it for one cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC)
        begin
            result_reg.hits           <= hits_n;
            result_reg.misses         <= misses_n;
            result_reg.evictions      <= evicts_n;
            result_reg.total_hits     <= hit_total_reg + 32'(hits_n);
            result_reg.total_misses   <= miss_total_reg + 32'(misses_n);
            result_reg.eviction_count <= evict_total_reg + 32'(evicts_n);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

[bench/tb_set_assoc_lru_cache_sim.sv]
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim
// Self-checking bench for the set-associative LRU cache. A scoreboard object
// keeps its own copy of the tags, valid flags and recency ranks, and works
// out the result of every accepted access. Each strobed result is checked
// against the oldest outstanding prediction. A directed sequence is followed
// by constrained-pool random traffic across a range of cache settings.
// ----------------------------------------------------------------------------
import salc_pkg::*;

localparam int         CACHE_LINES = NUM_SETS * WAYS;

class cache_scoreboard;

    // Configuration as written, before saturation.
    logic [CFG_SET_W-1:0]  cfg_sets;
    logic [CFG_BLK_W-1:0]  cfg_block;
    logic [CFG_WAYS_W-1:0] cfg_ways;

    // Cache contents: one entry per line, set-major.
    bit                way_valid [CACHE_LINES];
    logic [31:0]       way_tag   [CACHE_LINES];
    logic [RANK_W-1:0] way_age   [CACHE_LINES];
    logic [31:0]       hit_sum;
    logic [31:0]       miss_sum;
    logic [31:0]       evict_sum;

    result_t           expected_results [$];
    int                mismatch_count;
    int                access_count;

    function new();
        int i;
        cfg_sets  = 4;
        cfg_block = 4;
        cfg_ways  = 1;
        for (i = 0; i < CACHE_LINES; i++)
        begin
            way_valid[i] = 1'b0;
            way_tag[i]   = '0;
            way_age[i]   = RANK_W'(i % WAYS);
        end
        hit_sum        = '0;
        miss_sum       = '0;
        evict_sum      = '0;
        mismatch_count = 0;
        access_count   = 0;
    endfunction

    function int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function int unsigned active_set_bits();
        return saturate(32'(cfg_sets), 1, MAX_SET_BITS);
    endfunction

    function int unsigned active_block_bits();
        return saturate(32'(cfg_block), 1, MAX_BLK_BITS);
    endfunction

    function int unsigned active_ways();
        return saturate(32'(cfg_ways), 1, WAYS);
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            REG_SET_BITS: cfg_sets  = value[CFG_SET_W-1:0];
            REG_BLK_BITS: cfg_block = value[CFG_BLK_W-1:0];
            REG_WAYS:     cfg_ways  = value[CFG_WAYS_W-1:0];
            default: ;
        endcase
    endfunction

    // Make one way the most recent; the ways that were more recent age by one.
    function void promote(int unsigned base, int unsigned way);
        logic [RANK_W-1:0] old_age;
        int unsigned       v;
        old_age = way_age[base + way];
        for (v = 0; v < WAYS; v++)
        begin
            if (way_age[base + v] < old_age)
                way_age[base + v] = way_age[base + v] + 1'b1;
        end
        way_age[base + way] = '0;
    endfunction

    // One lookup in a set: hit, fill an empty way or evict the oldest way.
    function void access_line(int unsigned set_idx, logic [31:0] tag, int unsigned nways,
                              inout result_t r);
        int unsigned base;
        int unsigned w;
        int unsigned pick;
        base = set_idx * WAYS;
        for (w = 0; w < nways; w++)
        begin
            if (way_valid[base + w] && way_tag[base + w] == tag)
            begin
                promote(base, w);
                r.hits  = r.hits + 1'b1;
                hit_sum = hit_sum + 1;
                return;
            end
        end
        r.misses = 1'b1;
        miss_sum = miss_sum + 1;
        pick     = nways;
        for (w = 0; w < nways; w++)
        begin
            if (!way_valid[base + w])
            begin
                pick = w;
                break;
            end
        end
        if (pick == nways)
        begin
            pick = 0;
            for (w = 1; w < nways; w++)
            begin
                if (way_age[base + w] > way_age[base + pick])
                    pick = w;
            end
            r.evictions = 1'b1;
            evict_sum   = evict_sum + 1;
        end
        way_valid[base + pick] = 1'b1;
        way_tag[base + pick]   = tag;
        promote(base, pick);
    endfunction

    // Note an accepted access transaction and queue the result it must give.
    function void note_access(access_t a);
        int unsigned s;
        int unsigned b;
        int unsigned set_idx;
        logic [31:0] tag;
        result_t     r;
        s       = active_set_bits();
        b       = active_block_bits();
        set_idx = (a.address >> b) & ((32'd1 << s) - 1);
        tag     = a.address & ~((32'd1 << (s + b)) - 1);
        r       = '0;
        if (a.opcode != OP_UNUSED)
            access_line(set_idx, tag, active_ways(), r);
        if (a.opcode == OP_MODIFY)
            access_line(set_idx, tag, active_ways(), r);
        r.total_hits     = hit_sum;
        r.total_misses   = miss_sum;
        r.eviction_count = evict_sum;
        expected_results.push_back(r);
        access_count++;
    endfunction

    // Check one result transaction against the oldest prediction.
    function void check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("ERROR: result strobed with no access outstanding: %p", got);
            return;
        end
        want = expected_results.pop_front();
        if (got.hits !== want.hits || got.misses !== want.misses ||
            got.evictions !== want.evictions || got.total_hits !== want.total_hits ||
            got.total_misses !== want.total_misses ||
            got.eviction_count !== want.eviction_count)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("ERROR: result mismatch");
                $display("  expected hits=%0d misses=%0d evictions=%0d totals=%0d/%0d/%0d",
                         want.hits, want.misses, want.evictions,
                         want.total_hits, want.total_misses, want.eviction_count);
                $display("  actual   hits=%0d misses=%0d evictions=%0d totals=%0d/%0d/%0d",
                         got.hits, got.misses, got.evictions,
                         got.total_hits, got.total_misses, got.eviction_count);
            end
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

endclass

module tb_set_assoc_lru_cache_sim;

    localparam int          RANDOM_ITEMS = 1880;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = RANDOM_ITEMS / PHASES;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          POOL_SIZE    = 6;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic              clk;
    logic              rst_n;
    logic              start;
    access_t           request;
    logic              busy;
    logic              done;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    cache_scoreboard   sb;
    int unsigned       cycle_count = 0;
    int                write_count;
    logic [31:0]       tag_pool [POOL_SIZE];

    set_assoc_lru_cache_sim DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Monitor: check strobed results and note accepted access transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_access(request);
        end
    end

    // Watchdog on the overall run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Present one access and hold it until the block takes it.
    task automatic send_access(input logic [31:0] addr, input logic [1:0] op);
        start           <= 1'b1;
        request.address <= addr;
        request.opcode  <= op;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sometimes leave a gap after a transaction.
    task automatic idle_gap(input int pct);
        int n;
        if ($urandom_range(0, 99) < pct)
        begin
            n = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup phase, then access phase until pready.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        write_count++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write all three registers; unused upper data bits carry random junk.
    task automatic write_setting(input int s, input int b, input int w);
        wait_drained();
        write_register(REG_SET_BITS, ($urandom << CFG_SET_W) | s);
        write_register(REG_BLK_BITS, ($urandom << CFG_BLK_W) | b);
        write_register(REG_WAYS, ($urandom << CFG_WAYS_W) | w);
    endtask

    // Cache settings for the random part, extremes and out-of-range values included.
    task automatic apply_phase(input int p);
        int k;
        case (p)
            0: write_setting(1, 1, 1);
            1: write_setting(8, 16, 4);
            2: write_setting(0, 0, 0);
            3: write_setting(15, 31, 7);
            4: write_setting(2, 6, 2);
            5: write_setting(3, 4, 3);
            6: write_setting(5, 12, 5);
            default: write_setting(1, 16, 4);
        endcase
        for (k = 0; k < POOL_SIZE; k++)
            tag_pool[k] = $urandom;
    endtask

    // Stimulus.
    initial
    begin
        int          i;
        int          pct;
        int unsigned s;
        int unsigned b;
        logic [31:0] addr;
        logic [1:0]  op;
        int          roll;

        sb          = new();
        write_count = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset geometry, one way; hit in block, eviction, modify, unused opcode.
        send_access(32'h0000_0000, OP_LOAD);
        send_access(32'h0000_0004, OP_LOAD);
        send_access(32'h0000_0100, OP_STORE);
        send_access(32'h0000_0000, OP_MODIFY);
        send_access(32'hFFFF_FFFF, OP_UNUSED);
        send_access(32'hFFFF_FFFF, OP_LOAD);
        send_access(32'hFFFF_FFF0, OP_MODIFY);

        // Four ways: fill a set, then force an LRU eviction.
        wait_drained();
        write_register(REG_WAYS, 32'd4);
        send_access(32'h0000_0100, OP_LOAD);
        send_access(32'h0000_0200, OP_STORE);
        send_access(32'h0000_0300, OP_LOAD);
        send_access(32'h0000_0400, OP_LOAD);
        send_access(32'h0000_0100, OP_LOAD);
        send_access(32'h0000_0500, OP_MODIFY);

        // Narrow to two ways and widen again: lines beyond the ways in use are kept.
        wait_drained();
        write_register(REG_WAYS, 32'd2);
        send_access(32'h0000_0300, OP_LOAD);
        wait_drained();
        write_register(REG_WAYS, 32'd4);
        send_access(32'h0000_0300, OP_LOAD);

        // Registers below and above their ranges saturate.
        write_setting(0, 0, 0);
        send_access(32'hFFFF_FFFF, OP_LOAD);
        send_access(32'h0000_0000, OP_LOAD);
        send_access(32'h0000_0000, OP_UNUSED);
        write_setting(15, 31, 7);
        send_access(32'hFFFF_FFFF, OP_LOAD);
        send_access(32'h1234_5678, OP_MODIFY);
        send_access(32'h0000_0000, OP_STORE);

        // Random traffic drawn from a small pool of tags and sets so that hits,
        // fills and evictions all occur, with some fully random noise.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_ITEMS == 0)
                apply_phase(i / PHASE_ITEMS);
            if (i < RANDOM_ITEMS / 3)
                pct = 14;
            else if (i < 2 * RANDOM_ITEMS / 3)
                pct = 71;
            else
                pct = 0;
            s = sb.active_set_bits();
            b = sb.active_block_bits();
            if ($urandom_range(0, 99) < 15)
                addr = $urandom;
            else
                addr = (tag_pool[$urandom_range(0, POOL_SIZE - 1)] << (s + b)) |
                       ((32'($urandom_range(0, 3)) & ((32'd1 << s) - 1)) << b) |
                       ($urandom & ((32'd1 << b) - 1));
            roll = $urandom_range(0, 99);
            if (roll < 5)
                op = OP_UNUSED;
            else if (roll < 40)
                op = OP_LOAD;
            else if (roll < 75)
                op = OP_STORE;
            else
                op = OP_MODIFY;
            send_access(addr, op);
            idle_gap(pct);
        end

        // Let everything outstanding come back, then report.
        wait_drained();
        $display("Checked %0d access transactions under %0d register writes.",
                 sb.access_count, write_count);
        $display("Predicted totals: %0d hits, %0d misses, %0d evictions; %0d mismatches.",
                 sb.hit_sum, sb.miss_sum, sb.evict_sum, sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
